// ===== rtl/core/mbi_pkg.sv =====
// Shared types and constants for the map bilinear interpolator.
// Used by mbi_front, mbi_back, the top level and the testbench; depends on nothing.
package mbi_pkg;

    // Request kinds carried in the slave-side tuser field.
    typedef enum logic [1:0] {
        REQ_XPOINT = 2'd0,
        REQ_YPOINT = 2'd1,
        REQ_CELL   = 2'd2,
        REQ_QUERY  = 2'd3
    } t_req;

    // Configuration register indexes (byte address is 4 times the index).
    typedef enum logic [1:0] {
        REG_X_POINTS    = 2'd0,
        REG_Y_POINTS    = 2'd1,
        REG_DATA_GAIN   = 2'd2,
        REG_DATA_OFFSET = 2'd3
    } t_reg;

    localparam logic [4:0]  RST_POINTS = 5'd16;
    localparam logic [31:0] RST_GAIN   = 32'd65536;
    localparam logic [31:0] RST_OFFSET = 32'd0;

    localparam int FRAC_W    = 17;  // fraction 0..65536
    localparam int DIV_STEPS = 17;  // one quotient bit per step
    localparam int VAL_W     = 48;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        t_req               kind;
        logic [7:0]         index;
        logic signed [15:0] write_value;
        logic signed [15:0] x_query;
        logic signed [15:0] y_query;
    } t_item;

    // Head of the queue between front and back.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    typedef struct packed {
        logic                    valid_res;
        logic signed [VAL_W-1:0] value;
        logic [3:0]              x_index;
        logic [3:0]              y_index;
        logic signed [15:0]      x_echo;
        logic signed [15:0]      y_echo;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE, S_FIRST, S_LAST, S_SCAN, S_DIV, S_CADDR, S_C1, S_C2,
        S_C3, S_C4, S_M1, S_M2, S_M3, S_M4, S_M5, S_OUT
    } t_state;

endpackage

// ===== rtl/core/mbi_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the axis and cell stores.
module mbi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/mbi_front.sv =====
// Front end: accepts words, drops out-of-range writes, queues the rest.
// Depends on mbi_pkg.
module mbi_front import mbi_pkg::*; #(
    parameter int MAX_X_POINTS = 16,
    parameter int MAX_Y_POINTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_req,
    input  logic [7:0]         i_index,
    input  logic signed [15:0] i_wval,
    input  logic signed [15:0] i_xq,
    input  logic signed [15:0] i_yq,
    output t_head              o_head,
    input  logic               i_pop
);

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       keep, push;
    t_item      item;

    assign item = '{kind: t_req'(i_req), index: i_index, write_value: i_wval,
                    x_query: i_xq, y_query: i_yq};

    always_comb begin
        unique case (t_req'(i_req))
            REQ_XPOINT: keep = int'(i_index) < MAX_X_POINTS;
            REQ_YPOINT: keep = int'(i_index) < MAX_Y_POINTS;
            REQ_CELL:   keep = int'(i_index) < MAX_X_POINTS * MAX_Y_POINTS;
            default:    keep = 1'b1;
        endcase
    end

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready && keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= item;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_mem[r_rp];

endmodule

// ===== rtl/core/mbi_back.sv =====
// Back end: executes store writes and runs the query sequencer (bracket search,
// serial division, cell fetch, interpolation, scaling). Depends on mbi_pkg, mbi_ram.
module mbi_back import mbi_pkg::*; #(
    parameter int MAX_X_POINTS = 16,
    parameter int MAX_Y_POINTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_head              i_head,
    output logic               o_pop,
    input  logic [4:0]         i_x_points,
    input  logic [4:0]         i_y_points,
    input  logic signed [31:0] i_gain,
    input  logic signed [31:0] i_offset,
    output t_result            o_res,
    output logic               o_res_valid,
    input  logic               i_res_ready
);

    localparam int XW  = $clog2(MAX_X_POINTS);
    localparam int YW  = $clog2(MAX_Y_POINTS);
    localparam int CD  = MAX_X_POINTS * MAX_Y_POINTS;
    localparam int CW  = $clog2(CD);
    localparam int NXW = $clog2(MAX_X_POINTS + 1);
    localparam int NYW = $clog2(MAX_Y_POINTS + 1);
    localparam int AW  = (XW > YW) ? XW : YW;
    localparam int NW  = (NXW > NYW) ? NXW : NYW;

    t_state                  r_state, n_state;
    logic                    r_axis;
    logic [AW-1:0]           r_i, r_fidx;
    logic signed [15:0]      r_lo, r_xq, r_yq;
    logic [XW-1:0]           r_ix;
    logic [YW-1:0]           r_iy;
    logic [FRAC_W-1:0]       r_tx, r_ty;
    logic [17:0]             r_rem;
    logic [16:0]             r_den;
    logic [FRAC_W-1:0]       r_quo;
    logic [4:0]              r_dcnt;
    logic                    r_first;
    logic signed [15:0]      r_c00, r_c10, r_c01, r_c11;
    logic signed [32:0]      r_v0, r_v1;
    logic signed [51:0]      r_p2;
    logic signed [31:0]      r_v;
    logic signed [63:0]      r_p3;
    logic signed [VAL_W-1:0] r_val;
    logic                    r_vres;
    logic                    r_ovalid;
    t_result                 r_out;

    logic [NXW-1:0]     nx;
    logic [NYW-1:0]     ny;
    logic [NW-1:0]      n_cur;
    logic signed [15:0] q, ard, xrd, yrd, crd;
    logic [AW-1:0]      n_aaddr;
    logic [CW-1:0]      n_caddr;
    logic               csel_x, csel_y;
    logic [XW-1:0]      ix1, colsel;
    logic [YW-1:0]      iy1, rowsel;
    logic               fin, div_start, q_start, q_bad, scan_adv;
    logic [AW-1:0]      fin_idx;
    logic [FRAC_W-1:0]  fin_frac;
    logic               xwe, ywe, cwe, out_load;
    logic signed [16:0] diff, den;
    logic [17:0]        dt, n_rem;
    logic               ge;
    logic [FRAC_W-1:0]  n_quo;
    logic signed [16:0] dc0, dc1;
    logic signed [34:0] m0, m1;
    logic signed [33:0] dv;
    logic signed [VAL_W:0] sum;

    assign nx = (int'(i_x_points) > MAX_X_POINTS) ? NXW'(MAX_X_POINTS) : NXW'(i_x_points);
    assign ny = (int'(i_y_points) > MAX_Y_POINTS) ? NYW'(MAX_Y_POINTS) : NYW'(i_y_points);

    assign n_cur = r_axis ? NW'(ny) : NW'(nx);
    assign q     = r_axis ? r_yq : r_xq;
    assign ard   = r_axis ? yrd : xrd;

    // Serial restoring division: first step compares without a shift.
    assign diff  = {q[15], q} - {r_lo[15], r_lo};
    assign den   = {ard[15], ard} - {r_lo[15], r_lo};
    assign dt    = r_first ? r_rem : {r_rem[16:0], 1'b0};
    assign ge    = dt >= {1'b0, r_den};
    assign n_rem = ge ? dt - {1'b0, r_den} : dt;
    assign n_quo = {r_quo[FRAC_W-2:0], ge};

    assign ix1    = (int'(r_ix) + 1 < int'(nx)) ? XW'(int'(r_ix) + 1) : r_ix;
    assign iy1    = (int'(r_iy) + 1 < int'(ny)) ? YW'(int'(r_iy) + 1) : r_iy;
    assign colsel = csel_x ? ix1 : r_ix;
    assign rowsel = csel_y ? iy1 : r_iy;
    assign n_caddr = CW'(int'(rowsel) * int'(nx) + int'(colsel));

    assign dc0 = {r_c10[15], r_c10} - {r_c00[15], r_c00};
    assign dc1 = {r_c11[15], r_c11} - {r_c01[15], r_c01};
    assign m0  = dc0 * $signed({1'b0, r_tx});
    assign m1  = dc1 * $signed({1'b0, r_tx});
    assign dv  = 34'(r_v1) - 34'(r_v0);
    assign sum = (VAL_W+1)'(r_p3 >>> 16) + (VAL_W+1)'(i_offset);

    assign out_load = (r_state == S_OUT) && (!r_ovalid || i_res_ready);

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        n_aaddr   = '0;
        csel_x    = 1'b0;
        csel_y    = 1'b0;
        fin       = 1'b0;
        fin_idx   = '0;
        fin_frac  = '0;
        div_start = 1'b0;
        scan_adv  = 1'b0;
        q_start   = 1'b0;
        q_bad     = 1'b0;
        xwe       = 1'b0;
        ywe       = 1'b0;
        cwe       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    case (i_head.item.kind)
                        REQ_XPOINT: xwe = 1'b1;
                        REQ_YPOINT: ywe = 1'b1;
                        REQ_CELL:   cwe = 1'b1;
                        default: begin
                            q_start = 1'b1;
                            if (nx < NXW'(2) || ny < NYW'(2)) begin
                                q_bad   = 1'b1;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_FIRST;
                            end
                        end
                    endcase
                end
            end
            S_FIRST: begin
                if (q <= ard) begin
                    fin = 1'b1;
                end else begin
                    n_aaddr = AW'(n_cur - NW'(1));
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                if (q >= ard) begin
                    fin     = 1'b1;
                    fin_idx = AW'(n_cur - NW'(1));
                end else begin
                    n_aaddr = AW'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (q >= r_lo && q <= ard) begin
                    fin_idx = r_i;
                    if (ard > r_lo) begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end else begin
                        fin = 1'b1;
                    end
                end else if (int'(r_i) + 2 >= int'(n_cur)) begin
                    // Unordered axis: nothing brackets the query.
                    fin     = 1'b1;
                    fin_idx = AW'(n_cur - NW'(1));
                end else begin
                    scan_adv = 1'b1;
                    n_aaddr  = AW'(int'(r_i) + 2);
                end
            end
            S_DIV: begin
                if (r_dcnt == 5'd1) begin
                    fin      = 1'b1;
                    fin_idx  = r_fidx;
                    fin_frac = n_quo;
                end
            end
            S_CADDR: n_state = S_C1;
            S_C1: begin
                csel_x  = 1'b1;
                n_state = S_C2;
            end
            S_C2: begin
                csel_y  = 1'b1;
                n_state = S_C3;
            end
            S_C3: begin
                csel_x  = 1'b1;
                csel_y  = 1'b1;
                n_state = S_C4;
            end
            S_C4: n_state = S_M1;
            S_M1: n_state = S_M2;
            S_M2: n_state = S_M3;
            S_M3: n_state = S_M4;
            S_M4: n_state = S_M5;
            S_M5: n_state = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (fin) begin
            n_state = r_axis ? S_CADDR : S_FIRST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_res_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_start) begin
            r_xq   <= i_head.item.x_query;
            r_yq   <= i_head.item.y_query;
            r_axis <= 1'b0;
            r_vres <= !q_bad;
            if (q_bad) begin
                r_val <= '0;
                r_ix  <= '0;
                r_iy  <= '0;
            end
        end
        if (r_state == S_FIRST) begin
            r_lo <= ard;
        end
        if (r_state == S_LAST) begin
            r_i <= '0;
        end
        if (scan_adv) begin
            r_lo <= ard;
            r_i  <= r_i + AW'(1);
        end
        if (div_start) begin
            r_rem   <= {1'b0, diff};
            r_den   <= den;
            r_quo   <= '0;
            r_dcnt  <= 5'(DIV_STEPS);
            r_first <= 1'b1;
            r_fidx  <= r_i;
        end
        if (r_state == S_DIV) begin
            r_rem   <= n_rem;
            r_quo   <= n_quo;
            r_dcnt  <= r_dcnt - 5'd1;
            r_first <= 1'b0;
        end
        if (fin) begin
            if (!r_axis) begin
                r_ix   <= XW'(fin_idx);
                r_tx   <= fin_frac;
                r_axis <= 1'b1;
            end else begin
                r_iy <= YW'(fin_idx);
                r_ty <= fin_frac;
            end
        end
        case (r_state)
            S_C1: r_c00 <= crd;
            S_C2: r_c10 <= crd;
            S_C3: r_c01 <= crd;
            S_C4: r_c11 <= crd;
            S_M1: begin
                r_v0 <= 33'((35'(r_c00) <<< 16) + m0);
                r_v1 <= 33'((35'(r_c01) <<< 16) + m1);
            end
            S_M2: r_p2 <= dv * $signed({1'b0, r_ty});
            S_M3: r_v <= 32'(34'(r_v0) + 34'(r_p2 >>> 16));
            S_M4: r_p3 <= r_v * i_gain;
            S_M5: begin
                if (sum[VAL_W] != sum[VAL_W-1]) begin
                    r_val <= sum[VAL_W] ? VAL_MIN : VAL_MAX;
                end else begin
                    r_val <= sum[VAL_W-1:0];
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_out <= '{valid_res: r_vres, value: r_val, x_index: 4'(r_ix),
                       y_index: 4'(r_iy), x_echo: r_xq, y_echo: r_yq};
        end
    end

    mbi_ram #(.WIDTH(16), .DEPTH(MAX_X_POINTS)) u_xram (
        .i_clk   (i_clk),
        .i_we    (xwe),
        .i_waddr (i_head.item.index[XW-1:0]),
        .i_wdata (i_head.item.write_value),
        .i_raddr (n_aaddr[XW-1:0]),
        .o_rdata (xrd)
    );

    mbi_ram #(.WIDTH(16), .DEPTH(MAX_Y_POINTS)) u_yram (
        .i_clk   (i_clk),
        .i_we    (ywe),
        .i_waddr (i_head.item.index[YW-1:0]),
        .i_wdata (i_head.item.write_value),
        .i_raddr (n_aaddr[YW-1:0]),
        .o_rdata (yrd)
    );

    mbi_ram #(.WIDTH(16), .DEPTH(CD)) u_cram (
        .i_clk   (i_clk),
        .i_we    (cwe),
        .i_waddr (CW'(i_head.item.index)),
        .i_wdata (i_head.item.write_value),
        .i_raddr (n_caddr),
        .o_rdata (crd)
    );

    assign o_res       = r_out;
    assign o_res_valid = r_ovalid;

    ap_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE))
        else $error("queue popped while a query is in progress");

    ap_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dcnt != 5'd0))
        else $error("divider running with an exhausted step count");

    ap_scan_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (int'(r_i) + 1 < int'(n_cur)))
        else $error("bracket scan past the last point");

    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_res_ready) |=> (r_ovalid && $stable(r_out)))
        else $error("pending result lost or changed under stall");

endmodule

// ===== rtl/core/map_bilinear_interpolator.sv =====
// Top level of the map bilinear interpolator: configuration registers and the
// front/back split. Depends on mbi_pkg, mbi_front, mbi_back (and mbi_ram below it).
//
// Usage: words arrive on the s_axis channel. tuser selects the request: load an
// x breakpoint, load a y breakpoint, load a table cell (row-major, stride
// x_points) or run a query. Loads produce no output; each query produces one
// word on m_axis with the scaled Q32.16 value, the bracket indexes and the
// query position echoed back. valid_res is low when either axis has fewer
// than two points in use.
// Sequence: a load executes from the queue head while the sequencer is idle. A
// query is taken from the queue and works on the x axis, then the y axis. On each
// it stops at the first point when the query clamps there and after reading the
// last point when it clamps at that end; otherwise it scans the breakpoints in
// turn through the axis RAM's single read port and runs the bit-serial fraction
// divider (skipped on a zero span). The query then does four cell RAM reads, the
// multiply chain and the output register load before the result word appears.
// A two-word queue lets the input keep accepting while a query runs. A result
// that is not taken stays in the output register and holds the sequencer; the
// queue then fills and s_axis_tready drops.
// Reset (synchronous, active low) restores the registers to 16, 16, gain 1.0,
// offset 0 and empties the queue; stores are undefined until loaded.
// The user must write configuration over the APB port only while the block is idle; the block does not enforce this.
module map_bilinear_interpolator import mbi_pkg::*; #(
    parameter int MAX_X_POINTS = 16,
    parameter int MAX_Y_POINTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: index[7:0], write_value[23:8], x_query[39:24], y_query[55:40]
    input  logic [55:0] s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: value[47:0], x_index[51:48], y_index[55:52], x_echo[71:56], y_echo[87:72]
    output logic [87:0] m_axis_tdata,
    // tuser: valid_res[0]
    output logic        m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [4:0]         r_x_points, r_y_points;
    logic signed [31:0] r_gain, r_offset;
    logic               cfg_wr;
    t_head              head;
    logic               pop;
    t_result            res;

    // Register file: writes complete on the access phase, no wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_points <= RST_POINTS;
            r_y_points <= RST_POINTS;
            r_gain     <= RST_GAIN;
            r_offset   <= RST_OFFSET;
        end else if (cfg_wr) begin
            unique case (t_reg'(paddr[3:2]))
                REG_X_POINTS:    r_x_points <= pwdata[4:0];
                REG_Y_POINTS:    r_y_points <= pwdata[4:0];
                REG_DATA_GAIN:   r_gain     <= pwdata;
                REG_DATA_OFFSET: r_offset   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[3:2]))
            REG_X_POINTS:    prdata = {27'd0, r_x_points};
            REG_Y_POINTS:    prdata = {27'd0, r_y_points};
            REG_DATA_GAIN:   prdata = r_gain;
            REG_DATA_OFFSET: prdata = r_offset;
            default:         prdata = '0;
        endcase
    end

    // Front end classifies words and queues them; the back end executes.
    mbi_front #(.MAX_X_POINTS(MAX_X_POINTS), .MAX_Y_POINTS(MAX_Y_POINTS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_req   (s_axis_tuser),
        .i_index (s_axis_tdata[7:0]),
        .i_wval  (s_axis_tdata[23:8]),
        .i_xq    (s_axis_tdata[39:24]),
        .i_yq    (s_axis_tdata[55:40]),
        .o_head  (head),
        .i_pop   (pop)
    );

    mbi_back #(.MAX_X_POINTS(MAX_X_POINTS), .MAX_Y_POINTS(MAX_Y_POINTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .i_x_points  (r_x_points),
        .i_y_points  (r_y_points),
        .i_gain      (r_gain),
        .i_offset    (r_offset),
        .o_res       (res),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tdata = {res.y_echo, res.x_echo, res.y_index, res.x_index, res.value};
    assign m_axis_tuser = res.valid_res;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for map_bilinear_interpolator: loads, queries and register writes.
// Depends on mbi_pkg and the RTL under rtl/core; results are predicted inside the bench.
module tb;
    import mbi_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata: index[7:0], write_value[23:8], x_query[39:24], y_query[55:40]
    logic [55:0] s_axis_tdata = '0;
    // tuser: req_type[1:0]
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata: value[47:0], x_index[51:48], y_index[55:52], x_echo[71:56], y_echo[87:72]
    logic [87:0] m_axis_tdata;
    // tuser: valid_res[0]
    logic        m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    map_bilinear_interpolator dut (.*);

    always #5 i_clk = ~i_clk;

    // Mirror of the block's stores and registers.
    logic signed [15:0] xaxis_mirror [16];
    logic signed [15:0] yaxis_mirror [16];
    logic signed [15:0] cell_mirror [256];
    logic [4:0]         xpts_mirror;
    logic [4:0]         ypts_mirror;
    logic signed [31:0] gain_mirror;
    logic signed [31:0] offset_mirror;

    t_result pending_results [$];
    int      mismatches = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    bit      rx_hold = 1'b0;
    longint  cycle_count = 0;

    localparam longint CYCLE_LIMIT = 2000000;

    // Finds the lower breakpoint and the Q1.16 fraction (up to 1.0) for one axis.
    task automatic bracket_axis(input logic signed [15:0] pts [16], input int n,
                                input longint q, output int idx, output longint frac);
        longint lo, hi;
        bit     found;
        frac  = 0;
        found = 0;
        if (q <= pts[0]) begin
            idx = 0;
        end else if (q >= pts[n-1]) begin
            idx = n - 1;
        end else begin
            idx = n - 1;
            for (int i = 0; i + 1 < n && !found; i++) begin
                lo = pts[i];
                hi = pts[i+1];
                if (q >= lo && q <= hi) begin
                    idx   = i;
                    found = 1;
                    if (hi > lo) frac = ((q - lo) * 65536) / (hi - lo);
                end
            end
        end
    endtask

    // Expected output word for one query under the current mirror state.
    task automatic interpolate_query(input logic signed [15:0] xq, input logic signed [15:0] yq,
                                     output t_result r);
        int     nx, ny, ix, iy, ix1, iy1;
        longint tx, ty, c00, c10, c01, c11, v0, v1, v, res;
        r = '0;
        r.x_echo = xq;
        r.y_echo = yq;
        nx = (xpts_mirror > 16) ? 16 : xpts_mirror;
        ny = (ypts_mirror > 16) ? 16 : ypts_mirror;
        if (nx >= 2 && ny >= 2) begin
            bracket_axis(xaxis_mirror, nx, longint'(xq), ix, tx);
            bracket_axis(yaxis_mirror, ny, longint'(yq), iy, ty);
            ix1 = (ix + 1 < nx) ? ix + 1 : ix;
            iy1 = (iy + 1 < ny) ? iy + 1 : iy;
            c00 = cell_mirror[iy * nx + ix];
            c10 = cell_mirror[iy * nx + ix1];
            c01 = cell_mirror[iy1 * nx + ix];
            c11 = cell_mirror[iy1 * nx + ix1];
            v0  = c00 * 65536 + (c10 - c00) * tx;
            v1  = c01 * 65536 + (c11 - c01) * tx;
            v   = v0 + (((v1 - v0) * ty) >>> 16);
            res = ((v * longint'(gain_mirror)) >>> 16) + longint'(offset_mirror);
            if (res > longint'(VAL_MAX)) res = VAL_MAX;
            if (res < longint'(VAL_MIN)) res = VAL_MIN;
            r.valid_res = 1'b1;
            r.value     = res[47:0];
            r.x_index   = ix[3:0];
            r.y_index   = iy[3:0];
        end
    endtask

    // Offers one word; tvalid stays high into the next call unless the sender idles.
    task automatic send_word(input t_req kind, input logic [7:0] idx,
                             input logic signed [15:0] wv,
                             input logic signed [15:0] xq, input logic signed [15:0] yq);
        t_result r;
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {yq, xq, wv, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        case (kind)
            REQ_XPOINT: if (idx < 16) xaxis_mirror[idx[3:0]] = wv;
            REQ_YPOINT: if (idx < 16) yaxis_mirror[idx[3:0]] = wv;
            REQ_CELL:   cell_mirror[idx] = wv;
            default: begin
                interpolate_query(xq, yq, r);
                pending_results.push_back(r);
            end
        endcase
    endtask

    // Drops tvalid and lets the block drain; loads leave no result behind,
    // so a fixed settle time after the last result lets queued loads execute.
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg which, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (which)
            REG_X_POINTS:  xpts_mirror = data[4:0];
            REG_Y_POINTS:  ypts_mirror = data[4:0];
            REG_DATA_GAIN: gain_mirror = data;
            default:       offset_mirror = data;
        endcase
    endtask

    // Point counts carry random upper bits, which the block must ignore.
    task automatic set_points(input int nx, input int ny);
        write_reg(REG_X_POINTS, {27'($urandom_range(0, 32'h07ff_ffff)), nx[4:0]});
        write_reg(REG_Y_POINTS, {27'($urandom_range(0, 32'h07ff_ffff)), ny[4:0]});
    endtask

    function automatic logic signed [15:0] rand16();
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic load_axis(input t_req kind, input int mode);
        int pts [16];
        for (int i = 0; i < 16; i++) pts[i] = $urandom_range(0, 65535) - 32768;
        if (mode == 1) for (int i = 0; i < 16; i++) pts[i] = pts[i] % 8;
        if (mode != 2) pts.sort();
        for (int i = 0; i < 16; i++) send_word(kind, 8'(i), 16'(pts[i]), rand16(), rand16());
    endtask

    task automatic query_random(input int n);
        int               lo_x, hi_x, lo_y, hi_y;
        logic signed [15:0] xq, yq;
        lo_x = xaxis_mirror[0];
        hi_x = xaxis_mirror[15];
        lo_y = yaxis_mirror[0];
        hi_y = yaxis_mirror[15];
        if (lo_x > hi_x) begin lo_x = hi_x; hi_x = xaxis_mirror[0]; end
        if (lo_y > hi_y) begin lo_y = hi_y; hi_y = yaxis_mirror[0]; end
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 8) begin
                xq = 16'($urandom_range(lo_x + 32768, hi_x + 32768) - 32768);
                yq = 16'($urandom_range(lo_y + 32768, hi_y + 32768) - 32768);
            end else begin
                xq = rand16();
                yq = rand16();
            end
            send_word(REQ_QUERY, 8'($urandom_range(0, 255)), rand16(), xq, yq);
        end
    endtask

    // Fills every store entry so that no query can touch an unloaded entry.
    task automatic test_load_stores();
        load_axis(REQ_XPOINT, 0);
        load_axis(REQ_YPOINT, 0);
        for (int i = 0; i < 256; i++) send_word(REQ_CELL, 8'(i), rand16(), rand16(), rand16());
        drain_block();
    endtask

    task automatic test_directed();
        // Extremes of the query range and exact breakpoints, reset registers.
        send_word(REQ_QUERY, 8'hff, 16'sh7fff, -16'sd32768, -16'sd32768);
        send_word(REQ_QUERY, 8'h00, -16'sd32768, 16'sh7fff, 16'sh7fff);
        send_word(REQ_QUERY, 8'h5a, 16'sh0, xaxis_mirror[3], yaxis_mirror[15]);
        send_word(REQ_QUERY, 8'ha5, 16'sh0, 16'(xaxis_mirror[7] + 1),
                  16'(yaxis_mirror[8] - 1));
        // Axis loads beyond the store depth must be dropped.
        send_word(REQ_XPOINT, 8'd16, 16'sh1234, 16'sh0, 16'sh0);
        send_word(REQ_YPOINT, 8'd255, -16'sd1, 16'sh0, 16'sh0);
        send_word(REQ_QUERY, 8'd0, 16'sh0, 16'(xaxis_mirror[15] - 1),
                  16'(yaxis_mirror[0] + 1));
        drain_block();
        // Fewer than two points on either axis.
        set_points(1, 16);
        send_word(REQ_QUERY, 8'd0, 16'sh0, 16'sh0123, -16'sd5);
        drain_block();
        set_points(16, 0);
        send_word(REQ_QUERY, 8'd0, 16'sh0, -16'sd300, 16'sh7000);
        drain_block();
        // Counts above the maximum saturate, minimum useful count is two.
        set_points(31, 17);
        send_word(REQ_QUERY, 8'd0, 16'sh0, 16'sh0011, 16'sh0022);
        drain_block();
        set_points(2, 2);
        send_word(REQ_QUERY, 8'd0, 16'sh0, 16'sh0, 16'sh0);
        drain_block();
        // Full-scale gain and offset, positive and then negative, exercise the scaling at its extremes.
        set_points(16, 16);
        write_reg(REG_DATA_GAIN, 32'h7fff_ffff);
        write_reg(REG_DATA_OFFSET, 32'h7fff_ffff);
        send_word(REQ_QUERY, 8'd0, 16'sh0, 16'(xaxis_mirror[5] + 3),
                  16'(yaxis_mirror[9] + 2));
        drain_block();
        write_reg(REG_DATA_GAIN, 32'h8000_0000);
        write_reg(REG_DATA_OFFSET, 32'h8000_0000);
        send_word(REQ_QUERY, 8'd0, 16'sh0, 16'(xaxis_mirror[2] + 1),
                  16'(yaxis_mirror[12] + 1));
        drain_block();
        // Zero-span intervals, then an axis that is not ordered.
        write_reg(REG_DATA_GAIN, RST_GAIN);
        write_reg(REG_DATA_OFFSET, RST_OFFSET);
        load_axis(REQ_XPOINT, 1);
        send_word(REQ_QUERY, 8'd0, 16'sh0, 16'sh0, 16'sh0);
        load_axis(REQ_YPOINT, 2);
        send_word(REQ_QUERY, 8'd0, 16'sh0, 16'sh3, 16'sh100);
        drain_block();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 21; ph++) begin
            if (ph < 7) begin
                send_idle_pct = 22;
                recv_idle_pct = 49;
            end else if (ph < 14) begin
                send_idle_pct = 49;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(9) == 0) set_points($urandom_range(0, 31), $urandom_range(0, 31));
            else set_points($urandom_range(2, 16), $urandom_range(2, 16));
            write_reg(REG_DATA_GAIN, ($urandom_range(3) == 0) ? $urandom()
                                     : $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
            write_reg(REG_DATA_OFFSET, $urandom());
            if ($urandom_range(3) != 0) load_axis(REQ_XPOINT, $urandom_range(9) < 7 ? 0 : 1 + (ph & 1));
            if ($urandom_range(3) != 0) load_axis(REQ_YPOINT, $urandom_range(9) < 7 ? 0 : 2 - (ph & 1));
            for (int i = 0; i < 10; i++) begin
                if ($urandom_range(4) == 0)
                    send_word(t_req'($urandom_range(0, 1)), 8'($urandom_range(16, 255)),
                              rand16(), rand16(), rand16());
                else
                    send_word(REQ_CELL, 8'($urandom_range(0, 255)), rand16(), rand16(),
                              rand16());
            end
            query_random(30);
            drain_block();
        end
    endtask

    // The receiver stops for a long stretch while queries keep coming.
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                rx_hold = 1'b1;
                repeat (800) @(posedge i_clk);
                rx_hold = 1'b0;
            end
        join_none
        query_random(12);
        drain_block();
    endtask

    // Checks each accepted result word against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want, got;
        if (m_axis_tvalid && m_axis_tready) begin
            got.valid_res = m_axis_tuser;
            got.value     = m_axis_tdata[47:0];
            got.x_index   = m_axis_tdata[51:48];
            got.y_index   = m_axis_tdata[55:52];
            got.x_echo    = m_axis_tdata[71:56];
            got.y_echo    = m_axis_tdata[87:72];
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word %h", $time, got);
            end else begin
                want = pending_results.pop_front();
                if (got.valid_res !== want.valid_res || got.value !== want.value ||
                    got.x_index !== want.x_index || got.y_index !== want.y_index ||
                    got.x_echo !== want.x_echo || got.y_echo !== want.y_echo) begin
                    mismatches++;
                    $display("%0t: expected valid=%0d value=%0d xi=%0d yi=%0d xe=%0d ye=%0d",
                             $time, want.valid_res, want.value, want.x_index, want.y_index,
                             want.x_echo, want.y_echo);
                    $display("%0t: actual   valid=%0d value=%0d xi=%0d yi=%0d xe=%0d ye=%0d",
                             $time, got.valid_res, got.value, got.x_index, got.y_index,
                             got.x_echo, got.y_echo);
                end
            end
        end
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        xpts_mirror   = RST_POINTS;
        ypts_mirror   = RST_POINTS;
        gain_mirror   = RST_GAIN;
        offset_mirror = RST_OFFSET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_load_stores();
        test_directed();
        test_output_stall();
        test_random_phases();
        test_output_stall();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
